// ----- hdl/sactag_pkg.sv -----
// Shared types, codes and command/status structs for the cache tag directory.
package sactag_pkg;

  // Configuration register indexes
  localparam logic CfgPolicy    = 1'b0;
  localparam logic CfgLineShift = 1'b1;
  localparam int   CfgIdxW      = 1;
  localparam int   CfgDataW     = 4;

  // Directory geometry: number of sets, a power of two
  localparam int   NumSets      = 512;

  // Replacement / prefetch policy codes
  localparam logic [1:0] PolAllocAlways = 2'd0;
  localparam logic [1:0] PolNoAllocSt   = 2'd1;
  localparam logic [1:0] PolNextLine    = 2'd2;
  localparam logic [1:0] PolPfOnMiss    = 2'd3;

  localparam logic [3:0] LineShiftRst = 4'd5;

  typedef struct packed {
    logic        mode;
    logic [31:0] address;
  } in_item_t;

  typedef struct packed {
    logic        hit;
    logic        prefetched;
    logic [31:0] hit_total;
  } out_item_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DEMAND,
    S_PF_READ,
    S_PF_UPDATE
  } ctrl_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic clr;      // write one cleared row
    logic rd_dem;   // capture item, read demand set
    logic rd_pf;    // read next-line set
    logic upd;      // update the row that was read
    logic upd_pf;   // the update is the prefetch access
    logic out;      // publish the result item
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic need_pf;
  } sts_t;

endpackage

// ----- hdl/sactag_ctrl.sv -----
// Sequencer for clearing pass, demand access and optional prefetch access.
module sactag_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  sactag_pkg::sts_t  sts,
  output sactag_pkg::cmd_t  cmd
);
  import sactag_pkg::*;

  ctrl_state_t state_r, state_nxt;

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR:     if (sts.clr_last) state_nxt = S_IDLE;
      S_IDLE:      if (start) state_nxt = S_DEMAND;
      S_DEMAND:    state_nxt = sts.need_pf ? S_PF_READ : S_IDLE;
      S_PF_READ:   state_nxt = S_PF_UPDATE;
      S_PF_UPDATE: state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      S_CLEAR: cmd.clr = 1'b1;
      S_IDLE: begin
        busy       = 1'b0;
        cmd.rd_dem = start;
      end
      S_DEMAND: begin
        cmd.upd = 1'b1;
        cmd.out = !sts.need_pf;
      end
      S_PF_READ: cmd.rd_pf = 1'b1;
      S_PF_UPDATE: begin
        cmd.upd    = 1'b1;
        cmd.upd_pf = 1'b1;
        cmd.out    = 1'b1;
      end
      default: busy = 1'b1;
    endcase
  end

  a_pf_follows: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PF_READ |=> state_r == S_PF_UPDATE)
    else $error("prefetch read not followed by update");
  a_out_after_upd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out |-> cmd.upd)
    else $error("result published without a directory update");
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_dem |=> state_r == S_DEMAND)
    else $error("accepted item did not start a demand access");

endmodule

// ----- hdl/sactag_dp.sv -----
// Tag/valid/recency memory, lookup, LRU update, hit counter and result register.
module sactag_dp #(
  parameter int NUM_WAYS   = 4,
  parameter int ADDR_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [sactag_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [sactag_pkg::CfgDataW-1:0]     cfg_wdata,
  input  sactag_pkg::in_item_t                in_item,
  input  sactag_pkg::cmd_t                    cmd,
  output sactag_pkg::sts_t                    sts,
  output logic                                out_valid,
  output sactag_pkg::out_item_t               out_item
);
  import sactag_pkg::*;

  // NUM_SETS is a power of two
  localparam int NUM_SETS = NumSets;
  localparam int SET_SH = $clog2(NUM_SETS);
  localparam int IDX_W  = (NUM_SETS > 1) ? SET_SH : 1;
  localparam int TAG_W  = (ADDR_WIDTH - SET_SH > 0) ? ADDR_WIDTH - SET_SH : 1;
  localparam int RW     = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int WAY_W  = RW;
  localparam int ENT_W  = 1 + TAG_W + RW;
  localparam int ROW_W  = NUM_WAYS * ENT_W;

  logic [1:0]            policy_r;
  logic [3:0]            line_shift_r;
  logic                  mode_r;
  logic [ADDR_WIDTH-1:0] addr_r;
  logic [IDX_W-1:0]      set_r;
  logic [TAG_W-1:0]      tag_r;
  logic [ROW_W-1:0]      row_r;
  logic [IDX_W-1:0]      clr_idx_r;
  logic                  dem_hit_r;
  logic [31:0]           hits_r, hits_nxt;
  logic                  out_valid_r;
  out_item_t             out_item_r;
  logic [ROW_W-1:0]      mem [NUM_SETS];

  logic [63:0]           in_addr64;
  logic [ADDR_WIDTH-1:0] dem_addr, pf_addr, lk_addr, lk_line, lk_tag_full;
  logic [IDX_W-1:0]      lk_set;
  logic [TAG_W-1:0]      lk_tag;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r     <= PolAllocAlways;
      line_shift_r <= LineShiftRst;
    end else if (cfg_we) begin
      if (cfg_index == CfgPolicy) policy_r <= cfg_wdata[1:0];
      if (cfg_index == CfgLineShift) line_shift_r <= cfg_wdata;
    end
  end

  // Split lookup address into set and tag
  assign in_addr64   = {32'b0, in_item.address};
  assign dem_addr    = in_addr64[ADDR_WIDTH-1:0];
  assign pf_addr     = addr_r + (ADDR_WIDTH'(1) << line_shift_r);
  assign lk_addr     = cmd.rd_pf ? pf_addr : dem_addr;
  assign lk_line     = lk_addr >> line_shift_r;
  assign lk_tag_full = lk_line >> SET_SH;
  assign lk_tag      = lk_tag_full[TAG_W-1:0];
  assign lk_set      = (NUM_SETS > 1) ? lk_line[IDX_W-1:0] : '0;

  // Capture item and lookup key
  always_ff @(posedge clk) begin
    if (cmd.rd_dem) begin
      mode_r <= in_item.mode;
      addr_r <= dem_addr;
    end
    if (cmd.rd_dem || cmd.rd_pf) begin
      set_r <= lk_set;
      tag_r <= lk_tag;
    end
  end

  // Row update logic
  logic [NUM_WAYS-1:0]           v_old;
  logic [NUM_WAYS-1:0][TAG_W-1:0] t_old;
  logic [NUM_WAYS-1:0][RW-1:0]   r_old;
  logic [ROW_W-1:0]              row_new;
  logic                          hit, has_inv, allocate, do_wr;
  logic [WAY_W-1:0]              hit_way, inv_way, lru_way, tgt;
  logic [RW-1:0]                 oldest;
  logic [RW:0]                   tgt_rank;

  always_comb begin
    v_old = '0; t_old = '0; r_old = '0;
    hit = 1'b0; has_inv = 1'b0;
    hit_way = '0; inv_way = '0; lru_way = '0; oldest = '0;
    for (int i = 0; i < NUM_WAYS; i++) begin
      v_old[i] = row_r[i*ENT_W];
      t_old[i] = row_r[i*ENT_W+1 +: TAG_W];
      r_old[i] = row_r[i*ENT_W+1+TAG_W +: RW];
    end
    for (int i = NUM_WAYS - 1; i >= 0; i--) begin
      if (v_old[i] && t_old[i] == tag_r) begin
        hit = 1'b1; hit_way = WAY_W'(i);
      end
      if (!v_old[i]) begin
        has_inv = 1'b1; inv_way = WAY_W'(i);
      end
    end
    for (int i = 0; i < NUM_WAYS; i++) begin
      if (r_old[i] >= oldest) begin
        oldest = r_old[i]; lru_way = WAY_W'(i);
      end
    end
    tgt      = hit ? hit_way : (has_inv ? inv_way : lru_way);
    allocate = cmd.upd_pf || !(policy_r == PolNoAllocSt && mode_r);
    do_wr    = cmd.upd && (hit || allocate);
    tgt_rank = v_old[tgt] ? {1'b0, r_old[tgt]} : (RW+1)'(NUM_WAYS);
    row_new  = row_r;
    for (int i = 0; i < NUM_WAYS; i++) begin
      if (WAY_W'(i) == tgt) begin
        row_new[i*ENT_W] = 1'b1;
        row_new[i*ENT_W+1 +: TAG_W] = tag_r;
        row_new[i*ENT_W+1+TAG_W +: RW] = '0;
      end else if (v_old[i] && {1'b0, r_old[i]} < tgt_rank) begin
        row_new[i*ENT_W+1+TAG_W +: RW] = r_old[i] + 1'b1;
      end
    end
  end

  // Directory memory: clear, write back, read
  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      mem[clr_idx_r] <= '0;
    end else if (do_wr) begin
      mem[set_r] <= row_new;
    end
    if (cmd.rd_dem || cmd.rd_pf) begin
      row_r <= mem[lk_set];
    end
  end

  // Advance clearing pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
    end else if (cmd.clr) begin
      clr_idx_r <= clr_idx_r + 1'b1;
    end
  end

  assign sts.clr_last = (clr_idx_r == IDX_W'(NUM_SETS - 1));
  assign sts.need_pf  = (policy_r == PolNextLine) || (policy_r == PolPfOnMiss && !hit);

  // Saturating demand hit counter
  assign hits_nxt = (cmd.upd && !cmd.upd_pf && hit && hits_r != '1) ? hits_r + 1'b1 : hits_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hits_r <= '0;
    end else begin
      hits_r <= hits_nxt;
    end
    if (cmd.upd && !cmd.upd_pf) dem_hit_r <= hit;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.out;
    end
    if (cmd.out) begin
      out_item_r.hit        <= cmd.upd_pf ? dem_hit_r : hit;
      out_item_r.prefetched <= cmd.upd_pf;
      out_item_r.hit_total  <= hits_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ----- hdl/set_assoc_lru_cache_tags.sv -----
// An accepted item passes the demand state, and with a prefetch access also the prefetch
// read and update states; the last of them sets the result register. The next item is taken
// only in the idle state, after one read and one write-back of the set memory per access.
// Reset: synchronous; a clearing pass then writes every set with busy high.
// Results are a one-cycle strobe on out_valid; the receiver cannot stall.
module set_assoc_lru_cache_tags #(
  parameter int NUM_WAYS   = 4,
  parameter int ADDR_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  sactag_pkg::in_item_t            in_item,
  output logic                            out_valid,
  output sactag_pkg::out_item_t           out_item,
  input  logic                            cfg_we,
  input  logic [sactag_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [sactag_pkg::CfgDataW-1:0] cfg_wdata
);
  import sactag_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sactag_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  sactag_dp #(
    .NUM_WAYS   (NUM_WAYS),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the set-associative LRU cache tag directory.
`timescale 1ns / 1ps

module tb_top;
  import sactag_pkg::*;

  localparam int Sets      = 512;
  localparam int Ways      = 4;
  localparam int CycleCap  = 200000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  in_item_t            in_item = '0;
  logic                out_valid;
  out_item_t           out_item;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = CfgPolicy;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  set_assoc_lru_cache_tags dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  // Directory mirror and its settings
  bit          mir_valid [Sets*Ways];
  logic [31:0] mir_tag   [Sets*Ways];
  logic [1:0]  mir_rank  [Sets*Ways];
  logic [31:0] mir_hits;
  logic [1:0]  mir_policy;
  logic [3:0]  mir_shift;

  out_item_t   expected_q[$];
  int          mismatches = 0;
  int          cycles = 0;
  bit          allow_idle;

  typedef struct {
    bit                 is_cfg;
    logic [CfgIdxW-1:0] idx;
    logic [3:0]         val;
    in_item_t           item;
    bit                 typed;
    out_item_t          res;
  } dir_row_t;

  dir_row_t plan[$];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Make way w most recent, aging the more recent valid ways
  task automatic make_recent(input int base, input int w);
    int r;
    r = mir_valid[base+w] ? mir_rank[base+w] : Ways;
    for (int i = 0; i < Ways; i++) begin
      if (i != w && mir_valid[base+i] && mir_rank[base+i] < r) mir_rank[base+i]++;
    end
    mir_valid[base+w] = 1'b1;
    mir_rank[base+w]  = '0;
  endtask

  task automatic lookup_line(input logic [31:0] addr, input bit alloc, output bit hit);
    logic [31:0] line, tg;
    int base, victim, oldest;
    line   = addr >> mir_shift;
    tg     = line >> 9;
    base   = int'(line[8:0]) * Ways;
    victim = 0;
    oldest = 0;
    hit    = 1'b0;
    for (int i = 0; i < Ways; i++) begin
      if (mir_valid[base+i] && mir_tag[base+i] == tg) begin
        make_recent(base, i);
        hit = 1'b1;
        return;
      end
    end
    if (!alloc) return;
    for (int i = 0; i < Ways; i++) begin
      if (!mir_valid[base+i]) begin
        mir_tag[base+i] = tg;
        make_recent(base, i);
        return;
      end
    end
    for (int i = 0; i < Ways; i++) begin
      if (mir_rank[base+i] >= oldest) begin
        oldest = mir_rank[base+i];
        victim = i;
      end
    end
    mir_tag[base+victim] = tg;
    make_recent(base, victim);
  endtask

  // Advance the mirror by one item, with its prefetch access if any, and return the status it should report
  task automatic predict_access(input in_item_t it, output out_item_t res);
    bit hit, pf_hit, pf;
    lookup_line(it.address, !(mir_policy == PolNoAllocSt && it.mode), hit);
    if (hit && mir_hits != 32'hFFFF_FFFF) mir_hits++;
    pf = (mir_policy == PolNextLine) || (mir_policy == PolPfOnMiss && !hit);
    if (pf) lookup_line(it.address + (32'd1 << mir_shift), 1'b1, pf_hit);
    res = '{hit: hit, prefetched: pf, hit_total: mir_hits};
  endtask

  // Check each strobed status against the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected item", out_item.hit_total, 32'd0);
      end else begin
        want = expected_q.pop_front();
        if (out_item.hit !== want.hit)
          report_mismatch("hit", 32'(out_item.hit), 32'(want.hit));
        if (out_item.prefetched !== want.prefetched)
          report_mismatch("prefetched", 32'(out_item.prefetched), 32'(want.prefetched));
        if (out_item.hit_total !== want.hit_total)
          report_mismatch("hit_total", out_item.hit_total, want.hit_total);
      end
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleCap) begin
      $display("[set_assoc_lru_cache_tags] ERROR");
      $finish;
    end
  end

  // Hold until nothing is expected and the block is idle
  task automatic drain();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [3:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CfgPolicy) mir_policy = val[1:0];
    else mir_shift = val;
    @(posedge clk);
  endtask

  // Issue one item, optionally after a random gap; typed results override the mirror
  task automatic issue_item(input in_item_t it, input bit typed, input out_item_t typed_res);
    out_item_t res;
    if (allow_idle && $urandom_range(99) < 27) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    predict_access(it, res);
    expected_q = {expected_q, (typed ? typed_res : res)};
  endtask

  // Append one row to the stimulus table
  function automatic void add_row(input dir_row_t r);
    plan = {plan, r};
  endfunction

  function automatic dir_row_t cfg_row(input logic [CfgIdxW-1:0] idx, input logic [3:0] val);
    dir_row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.val    = val;
    return r;
  endfunction

  function automatic dir_row_t access_row(input logic m, input logic [31:0] a, input bit typed,
                                          input logic h, input logic p, input logic [31:0] t);
    dir_row_t r;
    r = '{default: '0};
    r.item  = '{mode: m, address: a};
    r.typed = typed;
    r.res   = '{hit: h, prefetched: p, hit_total: t};
    return r;
  endfunction

  // Random address from a small pool of tags and sets so hits and evictions happen
  function automatic logic [31:0] pick_address(input logic [31:0] tag_pool[8]);
    logic [31:0] a;
    if ($urandom_range(99) < 10) return $urandom;
    a = (tag_pool[$urandom_range(7)] << (mir_shift + 9))
        | (32'($urandom_range(15)) << mir_shift)
        | ($urandom & ((32'd1 << mir_shift) - 1));
    return a;
  endfunction

  initial begin
    dir_row_t    row;
    out_item_t   none;
    logic [31:0] tag_pool[8];
    logic [3:0]  shift_pick;
    int          sent;

    for (int i = 0; i < Sets*Ways; i++) begin
      mir_valid[i] = 1'b0;
      mir_tag[i]   = '0;
      mir_rank[i]  = '0;
    end
    mir_hits   = '0;
    mir_policy = PolAllocAlways;
    mir_shift  = LineShiftRst;
    none       = '0;
    allow_idle = 1'b1;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);

    // Cold misses, hits, address extremes
    add_row(access_row(1'b0, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 32'd0));
    add_row(access_row(1'b0, 32'h0000_001F, 1'b1, 1'b1, 1'b0, 32'd1));
    add_row(access_row(1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 32'd1));
    add_row(access_row(1'b0, 32'hFFFF_FFE0, 1'b1, 1'b1, 1'b0, 32'd2));
    // Store miss without allocation leaves the line out
    add_row(cfg_row(CfgPolicy, 4'(PolNoAllocSt)));
    add_row(access_row(1'b1, 32'h0000_1000, 1'b1, 1'b0, 1'b0, 32'd2));
    add_row(access_row(1'b0, 32'h0000_1000, 1'b1, 1'b0, 1'b0, 32'd2));
    add_row(access_row(1'b1, 32'h0000_1000, 1'b1, 1'b1, 1'b0, 32'd3));
    // Next-line fetch, wrapping past the top of the address space
    add_row(cfg_row(CfgPolicy, 4'(PolNextLine)));
    add_row(access_row(1'b0, 32'hFFFF_FFE0, 1'b1, 1'b1, 1'b1, 32'd4));
    add_row(access_row(1'b0, 32'h0000_0000, 1'b1, 1'b1, 1'b1, 32'd5));
    // Fetch on miss only
    add_row(cfg_row(CfgPolicy, 4'(PolPfOnMiss)));
    add_row(access_row(1'b0, 32'h0000_0020, 1'b1, 1'b1, 1'b0, 32'd6));
    add_row(access_row(1'b0, 32'h8000_0000, 1'b1, 1'b0, 1'b1, 32'd6));
    add_row(access_row(1'b0, 32'h8000_0020, 1'b1, 1'b1, 1'b0, 32'd7));
    // Widest line shift, then byte lines with an LRU eviction in one set
    add_row(cfg_row(CfgLineShift, 4'd15));
    add_row(access_row(1'b1, 32'h1234_5678, 1'b0, 1'b0, 1'b0, 32'd0));
    add_row(cfg_row(CfgPolicy, 4'(PolAllocAlways)));
    add_row(cfg_row(CfgLineShift, 4'd0));
    for (int k = 1; k <= 5; k++) begin
      add_row(access_row(1'b0, 32'(k * 512), 1'b0, 1'b0, 1'b0, 32'd0));
    end
    add_row(access_row(1'b0, 32'd512, 1'b0, 1'b0, 1'b0, 32'd0));
    add_row(access_row(1'b0, 32'd2560, 1'b0, 1'b0, 1'b0, 32'd0));

    foreach (plan[i]) begin
      row = plan[i];
      if (row.is_cfg) begin
        start <= 1'b0;
        drain();
        write_reg(row.idx, row.val);
      end else begin
        issue_item(row.item, row.typed, row.res);
      end
    end

    // Random phases over policy and line size
    for (int ph = 0; ph < 7; ph++) begin
      start <= 1'b0;
      drain();
      case (ph)
        0: shift_pick = 4'd0;
        1: shift_pick = 4'd12;
        2: shift_pick = 4'd15;
        3: shift_pick = 4'd5;
        default: shift_pick = 4'($urandom_range(15));
      endcase
      write_reg(CfgPolicy, 4'(ph % 4));
      write_reg(CfgLineShift, shift_pick);
      allow_idle = (ph != 2);
      for (int j = 0; j < 8; j++) tag_pool[j] = $urandom;
      sent = 0;
      while (sent < 250) begin
        issue_item('{mode: 1'($urandom_range(1)), address: pick_address(tag_pool)}, 1'b0,
                   none);
        sent++;
      end
    end
    start <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("[set_assoc_lru_cache_tags] OK");
    end else begin
      $display("[set_assoc_lru_cache_tags] ERROR");
    end
    $finish;
  end

endmodule
